/* src/lcgd_pkg.sv */
// Shared types and constants for the light cover gesture detector.
package lcgd_pkg;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_RELEASE_MODE   = 3'd0,
        REG_MIRROR_LOCK    = 3'd1,
        REG_TRIGGER_DROP   = 3'd2,
        REG_HOLD_DROP      = 3'd3,
        REG_WARMUP_SAMPLES = 3'd4,
        REG_WAVES_NEEDED   = 3'd5,
        REG_WAVE_TIMEOUT   = 3'd6
    } reg_index_t;

    // Release modes
    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_NEAR   = 2'd1,
        MODE_AWAY   = 2'd2,
        MODE_WAVE   = 2'd3
    } release_mode_t;

    // Item kinds on the input stream
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    localparam int EV_W = 14;
    localparam int DROP_W = 12;

    // Delayed-average history holds this value after reset
    localparam logic signed [EV_W-1:0] HIST_RESET = 14'sd1000;

    // Reset values of the registers
    localparam logic [DROP_W-1:0] TRIGGER_DROP_RESET = 12'd200;
    localparam logic [DROP_W-1:0] HOLD_DROP_RESET    = 12'd100;
    localparam logic [7:0]        WARMUP_RESET       = 8'd50;
    localparam logic [3:0]        WAVES_NEEDED_RESET = 4'd5;
    localparam logic [7:0]        WAVE_TIMEOUT_RESET = 8'd50;

    localparam logic [3:0] WAVE_COUNT_MAX = 4'd15;

    typedef struct packed {
        release_mode_t     release_mode;
        logic              mirror_lock_enabled;
        logic [DROP_W-1:0] trigger_drop;
        logic [DROP_W-1:0] hold_drop;
        logic [7:0]        warmup_samples;
        logic [3:0]        waves_needed;
        logic [7:0]        wave_timeout_ticks;
    } cfg_t;

    // Flag state handed from the level tracker to the release logic
    typedef struct packed {
        logic covered;
        logic covered_next;
    } track_t;

endpackage

/* src/light_cover_gesture_detector.sv */
// Top level of the light cover gesture detector: config port, release logic, output stage.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | tdata: light_ev, release_allowed, shot_pending
//           |     |                    | tuser: kind
//  m_       | out | m_tvalid/m_tready  | tdata: covered, fire_request,
//           |     |                    |        mirror_lock_request, waves_seen
//  apb      | in  | psel/penable       | paddr, pwdata, prdata (7 registers, 4-byte stride)
//
// One item per cycle unless m_tready stalls; each result is registered and appears in
// the cycle after its acceptance. Release and level state update at the accepting
// edge; the result register holds it until m_tready takes it, and s_tready follows
// its free slot. rst_n clears all but m_tdata, sets register defaults, history to 1000.
module light_cover_gesture_detector #(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [13:0] light_ev, [14] release_allowed, [15] shot_pending
    input  logic        s_tuser,   // [0] kind
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] covered, [1] fire_request,
                                   // [2] mirror_lock_request, [6:3] waves_seen, [7] zero
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lcgd_pkg::cfg_t   cfg_reg;
    lcgd_pkg::track_t track;

    logic        accept;
    logic        sample_en;
    logic        kind;
    logic        release_allowed;
    logic        shot_pending;
    logic signed [lcgd_pkg::EV_W-1:0] light_ev;

    logic        last_acted_reg;
    logic        last_acted_next;
    logic [7:0]  warmup_reg;
    logic [7:0]  warmup_next;
    logic [3:0]  wave_count_reg;
    logic [3:0]  wave_count_next;
    logic [7:0]  countdown_reg;
    logic [7:0]  countdown_next;
    logic        fire;
    logic        mlu;
    logic        covered_out;

    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;

    lcgd_pkg::reg_index_t reg_idx;

    assign kind            = s_tuser;
    assign light_ev        = $signed(s_tdata[13:0]);
    assign release_allowed = s_tdata[14];
    assign shot_pending    = s_tdata[15];

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign sample_en = accept && (kind == lcgd_pkg::KIND_SAMPLE);

    lcgd_level_track #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_en    (sample_en),
        .light_ev     (light_ev),
        .trigger_drop (cfg_reg.trigger_drop),
        .hold_drop    (cfg_reg.hold_drop),
        .track        (track)
    );

    // Configuration registers: write on the access phase
    assign pready  = 1'b1;
    assign reg_idx = lcgd_pkg::reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.release_mode        <= lcgd_pkg::MODE_OFF;
            cfg_reg.mirror_lock_enabled <= 1'b0;
            cfg_reg.trigger_drop        <= lcgd_pkg::TRIGGER_DROP_RESET;
            cfg_reg.hold_drop           <= lcgd_pkg::HOLD_DROP_RESET;
            cfg_reg.warmup_samples      <= lcgd_pkg::WARMUP_RESET;
            cfg_reg.waves_needed        <= lcgd_pkg::WAVES_NEEDED_RESET;
            cfg_reg.wave_timeout_ticks  <= lcgd_pkg::WAVE_TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx)
                lcgd_pkg::REG_RELEASE_MODE:
                    cfg_reg.release_mode <= lcgd_pkg::release_mode_t'(pwdata[1:0]);
                lcgd_pkg::REG_MIRROR_LOCK:    cfg_reg.mirror_lock_enabled <= pwdata[0];
                lcgd_pkg::REG_TRIGGER_DROP:   cfg_reg.trigger_drop <= pwdata[11:0];
                lcgd_pkg::REG_HOLD_DROP:      cfg_reg.hold_drop <= pwdata[11:0];
                lcgd_pkg::REG_WARMUP_SAMPLES: cfg_reg.warmup_samples <= pwdata[7:0];
                lcgd_pkg::REG_WAVES_NEEDED:   cfg_reg.waves_needed <= pwdata[3:0];
                lcgd_pkg::REG_WAVE_TIMEOUT:   cfg_reg.wave_timeout_ticks <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read mux
    always_comb
    begin
        unique case (reg_idx)
            lcgd_pkg::REG_RELEASE_MODE:   prdata = 32'(cfg_reg.release_mode);
            lcgd_pkg::REG_MIRROR_LOCK:    prdata = 32'(cfg_reg.mirror_lock_enabled);
            lcgd_pkg::REG_TRIGGER_DROP:   prdata = 32'(cfg_reg.trigger_drop);
            lcgd_pkg::REG_HOLD_DROP:      prdata = 32'(cfg_reg.hold_drop);
            lcgd_pkg::REG_WARMUP_SAMPLES: prdata = 32'(cfg_reg.warmup_samples);
            lcgd_pkg::REG_WAVES_NEEDED:   prdata = 32'(cfg_reg.waves_needed);
            lcgd_pkg::REG_WAVE_TIMEOUT:   prdata = 32'(cfg_reg.wave_timeout_ticks);
            default:                      prdata = '0;
        endcase
    end

    // Release logic and wave timeout
    always_comb
    begin
        last_acted_next = last_acted_reg;
        warmup_next     = warmup_reg;
        wave_count_next = wave_count_reg;
        countdown_next  = countdown_reg;
        fire            = 1'b0;
        mlu             = 1'b0;

        if (kind == lcgd_pkg::KIND_TICK)
        begin
            // Count down; clear the wave count when the timeout expires
            if (countdown_reg != '0)
            begin
                countdown_next = countdown_reg - 8'd1;
                if (countdown_reg == 8'd1)
                begin
                    wave_count_next = '0;
                end
            end
        end
        else if (warmup_reg < cfg_reg.warmup_samples)
        begin
            warmup_next = warmup_reg + 8'd1;
        end
        else if (track.covered_next != last_acted_reg)
        begin
            last_acted_next = track.covered_next;
            if (!shot_pending)
            begin
                if (cfg_reg.release_mode == lcgd_pkg::MODE_OFF || !release_allowed)
                begin
                    wave_count_next = '0;
                end
                else
                begin
                    case (cfg_reg.release_mode)
                        lcgd_pkg::MODE_NEAR:
                        begin
                            // Fire on cover, ignore uncover
                            if (track.covered_next)
                            begin
                                fire            = 1'b1;
                                wave_count_next = '0;
                            end
                        end
                        lcgd_pkg::MODE_AWAY:
                        begin
                            // Cover asks for mirror lock, uncover fires
                            if (track.covered_next)
                            begin
                                mlu = cfg_reg.mirror_lock_enabled;
                            end
                            else
                            begin
                                fire            = 1'b1;
                                wave_count_next = '0;
                            end
                        end
                        default:
                        begin
                            // Wave: count changes, fire once enough are seen
                            countdown_next = cfg_reg.wave_timeout_ticks;
                            if (wave_count_reg != lcgd_pkg::WAVE_COUNT_MAX)
                            begin
                                wave_count_next = wave_count_reg + 4'd1;
                            end
                            if (!(wave_count_next < cfg_reg.waves_needed))
                            begin
                                fire            = 1'b1;
                                wave_count_next = '0;
                            end
                        end
                    endcase
                end
            end
        end
    end

    assign covered_out = (kind == lcgd_pkg::KIND_TICK) ? track.covered : track.covered_next;

    // Advance release state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_acted_reg <= 1'b0;
            warmup_reg     <= '0;
            wave_count_reg <= '0;
            countdown_reg  <= '0;
        end
        else if (accept)
        begin
            last_acted_reg <= last_acted_next;
            warmup_reg     <= warmup_next;
            wave_count_reg <= wave_count_next;
            countdown_reg  <= countdown_next;
        end
    end

    // Output register: hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_tvalid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= {1'b0, wave_count_next, mlu, fire, covered_out};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* src/lcgd_level_track.sv */
// Running light average, delayed-average history and covered hysteresis flag.
module lcgd_level_track #(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_en,
    input  logic signed [lcgd_pkg::EV_W-1:0]    light_ev,
    input  logic [lcgd_pkg::DROP_W-1:0]         trigger_drop,
    input  logic [lcgd_pkg::DROP_W-1:0]         hold_drop,
    output lcgd_pkg::track_t                    track
);

    logic signed [lcgd_pkg::EV_W-1:0] avg_reg;
    logic signed [lcgd_pkg::EV_W-1:0] avg_next;
    logic signed [lcgd_pkg::EV_W-1:0] hist_reg [HISTORY_DEPTH];
    logic                             covered_reg;
    logic                             covered_next;

    logic signed [19:0] avg_sum;
    logic signed [19:0] avg_quot;
    logic signed [15:0] delta;
    logic signed [15:0] trig_neg;
    logic signed [15:0] hold_neg;

    // Average step: seed from the sample when unseeded, else 63/64 blend
    always_comb
    begin
        avg_sum  = ($signed(20'(avg_reg)) <<< 6) - 20'(avg_reg) + 20'(light_ev);
        // Truncate toward zero: bias negative sums before the shift
        avg_quot = (avg_sum + (avg_sum[19] ? 20'sd63 : 20'sd0)) >>> 6;
        if (avg_reg == '0)
        begin
            avg_next = light_ev;
        end
        else
        begin
            avg_next = avg_quot[lcgd_pkg::EV_W-1:0];
        end
    end

    // Hysteresis against the oldest history entry
    always_comb
    begin
        delta    = 16'(light_ev) - 16'(hist_reg[HISTORY_DEPTH-1]);
        trig_neg = 16'sd0 - $signed({4'b0, trigger_drop});
        hold_neg = 16'sd0 - $signed({4'b0, hold_drop});
        if (delta < trig_neg)
        begin
            covered_next = 1'b1;
        end
        else if (delta > hold_neg)
        begin
            covered_next = 1'b0;
        end
        else
        begin
            covered_next = covered_reg;
        end
    end

    // Advance average, history and flag on each light sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg     <= '0;
            covered_reg <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= lcgd_pkg::HIST_RESET;
            end
        end
        else if (sample_en)
        begin
            avg_reg     <= avg_next;
            covered_reg <= covered_next;
            hist_reg[0] <= avg_next;
            for (int i = 1; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    assign track.covered      = covered_reg;
    assign track.covered_next = covered_next;

endmodule
